[hdl/smt_pkg.sv]
// smt_pkg: request codes, field widths and the per-cell control bundle
// shared by the sorted membership table; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

  localparam int KEY_W     = 32;
  localparam int REQ_W     = 2;
  localparam int CNT_OUT_W = 9;
  localparam int OUT_TDATA_W = 16;

  // hit bits folded per first-level group of the lookup reduction
  localparam int GROUP_W = 16;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic             load;    // beat accepted this cycle
    logic             insert;  // insert that fits in the table
    logic             lookup;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/smt_cell.sv]
// smt_cell: one slot of the sorted chain; holds a value, shifts up from its
// lower neighbor on insert and registers its own lookup hit; uses smt_pkg
`timescale 1ns / 1ps
`default_nettype none

module smt_cell #(
  parameter int CW  = 9,
  parameter int IDX = 0
) (
  input  wire logic                     clk,
  input  wire smt_pkg::cell_ctl_t       ctl,
  input  wire logic [CW-1:0]            count,
  input  wire logic                     prev_gt,
  input  wire logic [smt_pkg::KEY_W-1:0] prev_value,
  output logic [smt_pkg::KEY_W-1:0]     value,
  output logic                          gt,
  output logic                          hit_r
);

  logic [smt_pkg::KEY_W-1:0] value_r;
  logic [smt_pkg::KEY_W-1:0] value_nxt;
  logic                      occ;
  logic                      is_tail;
  logic                      hit_nxt;

  assign occ     = CW'(IDX) < count;
  assign is_tail = CW'(IDX) == count;
  assign gt      = occ && (value_r > ctl.key);
  assign hit_nxt = ctl.lookup && occ && (value_r == ctl.key);
  assign value   = value_r;

  // larger values below move up one slot, the first slot not below a
  // larger value takes the new key
  always_comb begin
    value_nxt = value_r;
    if (ctl.insert) begin
      if (prev_gt) begin
        value_nxt = prev_value;
      end else if (gt || is_tail) begin
        value_nxt = ctl.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (ctl.load) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/smt_hit_reduce.sv]
// smt_hit_reduce: first registered level of the lookup or-tree, folding the
// per-cell hit bits into group flags; uses smt_pkg
`timescale 1ns / 1ps
`default_nettype none

module smt_hit_reduce #(
  parameter int N = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [N-1:0]             hits,
  output logic [((N + smt_pkg::GROUP_W - 1) / smt_pkg::GROUP_W)-1:0] grp_r
);

  localparam int G  = smt_pkg::GROUP_W;
  localparam int NG = (N + G - 1) / G;

  logic [NG*G-1:0] hits_pad;
  logic [NG-1:0]   grp_nxt;

  assign hits_pad = {{(NG*G-N){1'b0}}, hits};

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = |hits_pad[g*G +: G];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/sorted_membership_table.sv]
// sorted_membership_table: top level; chain of sorted cells, lookup
// reduction and the three-stage result pipeline; uses smt_pkg, smt_cell,
// smt_hit_reduce
//
// usage
//   input beat: in_tuser carries the request (insert, lookup, clear), in_tdata
//   the 32-bit key. every request returns exactly one result beat carrying
//   found, the entry count after the request and the dropped-insert flag.
//   the table is a row of CAPACITY cells kept in ascending order; an insert
//   shifts all larger cells up one slot in the cycle the beat is taken, a
//   lookup compares every occupied cell at once.
// throughput and result path
//   one request per cycle while out_tready does not stall the pipeline, set by
//   the parallel shift of the cell row. a result passes in turn through the cell
//   hit registers, the group or-level and the output register.
// reset
//   rst_n clears the entry count and the pipeline valids; cell contents
//   are left as they are and only slots below the count are ever looked at.
// back-pressure
//   when out_tready is low the output register holds; the two inner stages
//   fill behind it and in_tready drops only once the cell hit stage is full.
`timescale 1ns / 1ps
`default_nettype none

module sorted_membership_table #(
  parameter int CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] key
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [smt_pkg::OUT_TDATA_W-1:0] out_tdata  // [0] found, [9:1] entry_count,
                                                     // [10] full_drop, [15:11] zero
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NG = (CAPACITY + smt_pkg::GROUP_W - 1) / smt_pkg::GROUP_W;
  localparam int KW = smt_pkg::KEY_W;

  // ---------------------------------------------------------------- control
  logic          acc;
  logic          out_adv, s2_adv, s1_adv;
  logic          full;
  logic          is_insert, is_lookup, is_clear;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop;

  logic          s1_v_r, s2_v_r, out_v_r;
  logic [CW-1:0] s1_cnt_r, s2_cnt_r;
  logic          s1_drop_r, s2_drop_r;
  logic          out_found_r, out_drop_r;
  logic [CW+smt_pkg::CNT_OUT_W-1:0] cnt_ext;
  logic [smt_pkg::CNT_OUT_W-1:0]    out_cnt_r;

  smt_pkg::cell_ctl_t ctl;

  // pipeline moves whenever the stage ahead can take its beat
  assign out_adv   = !out_v_r || out_tready;
  assign s2_adv    = !s2_v_r || out_adv;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_tready = s1_adv;
  assign acc       = in_tvalid && in_tready;

  assign full      = cnt_r == CW'(CAPACITY);
  assign is_insert = in_tuser == smt_pkg::REQ_INSERT;
  assign is_lookup = in_tuser == smt_pkg::REQ_LOOKUP;
  assign is_clear  = in_tuser == smt_pkg::REQ_CLEAR;
  assign drop      = is_insert && full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      if (is_insert && !full) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (is_clear) begin
        cnt_nxt = '0;
      end
    end
  end

  assign ctl.load   = acc;
  assign ctl.insert = acc && is_insert && !full;
  assign ctl.lookup = is_lookup;
  assign ctl.key    = in_tdata;

  // ---------------------------------------------------------------- cell row
  logic [KW-1:0]       vals [CAPACITY];
  logic [CAPACITY-1:0] gts;
  logic [CAPACITY-1:0] hits;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          prev_gt;
    logic [KW-1:0] prev_value;
    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_value = '0;
    end else begin : g_link
      assign prev_gt    = gts[i-1];
      assign prev_value = vals[i-1];
    end
    smt_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (cnt_r),
      .prev_gt    (prev_gt),
      .prev_value (prev_value),
      .value      (vals[i]),
      .gt         (gts[i]),
      .hit_r      (hits[i])
    );
  end

  // ---------------------------------------------------------------- lookup or-tree
  logic [NG-1:0] grp_r;

  smt_hit_reduce #(
    .N (CAPACITY)
  ) u_reduce (
    .clk   (clk),
    .en    (s2_adv),
    .hits  (hits),
    .grp_r (grp_r)
  );

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_adv) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // payload side of the pipeline
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cnt_r  <= cnt_nxt;
      s1_drop_r <= drop;
    end
    if (s2_adv) begin
      s2_cnt_r  <= s1_cnt_r;
      s2_drop_r <= s1_drop_r;
    end
    if (out_adv) begin
      out_found_r <= |grp_r;
      out_cnt_r   <= cnt_ext[smt_pkg::CNT_OUT_W-1:0];
      out_drop_r  <= s2_drop_r;
    end
  end

  assign cnt_ext = {{smt_pkg::CNT_OUT_W{1'b0}}, s2_cnt_r};

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_drop_r, out_cnt_r, out_found_r};

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_drop_r |-> s1_cnt_r == CW'(CAPACITY))
    else $error("insert dropped while table not full");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_clear |=> cnt_r == '0)
    else $error("clear left entries behind");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_insert && !full |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the table by one");

  a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_found_r |-> !out_drop_r)
    else $error("found and drop flagged together");

endmodule

`default_nettype wire
